// ----- src/bdd_pkg.sv -----
// Shared types, widths and register codes for the band dwell detector.
`default_nettype none

package bdd_pkg;

  // Field widths fixed by the interface.
  localparam int SAMPLE_W   = 10;
  localparam int CNT_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Default window length.
  localparam int WINDOW_DEFAULT = 8;

  // Saturation value of the dwell counter.
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Operating modes.
  localparam logic MODE_AVG = 1'b0;
  localparam logic MODE_RAW = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD   = 3'd0,
    REG_BAND_WIDTH  = 3'd1,
    REG_DURATION    = 3'd2,
    REG_MODE        = 3'd3,
    REG_COUNT_START = 3'd4
  } cfg_reg_t;

  // Register set seen by the dwell stage.
  typedef struct packed {
    logic [SAMPLE_W-1:0] threshold;
    logic [SAMPLE_W-1:0] band_width;
    logic [CNT_W-1:0]    duration;
    logic [CNT_W-1:0]    count_start;
  } cfg_t;

  // Per-item control handed from the window stage to the dwell stage.
  typedef struct packed {
    logic raw;
    logic full;
  } stage_ctl_t;

endpackage

`default_nettype wire

// ----- src/bdd_cell.sv -----
// One storage cell of the sample chain: holds a sample and hands it on when the chain shifts.
`default_nettype none

module bdd_cell (
  input  wire logic                         clk,
  input  wire logic                         shift,
  input  wire logic [bdd_pkg::SAMPLE_W-1:0] d,
  output logic      [bdd_pkg::SAMPLE_W-1:0] q
);

  // The sample moves one place down the chain on every averaged item.
  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

`default_nettype wire

// ----- src/bdd_window.sv -----
// Sample window: chain of cells, running sum, fill level and the first pipeline stage.
`default_nettype none

module bdd_window #(
  parameter int WINDOW = bdd_pkg::WINDOW_DEFAULT
) (
  input  wire logic                                              clk,
  input  wire logic                                              rst,
  input  wire logic                                              accept,
  input  wire logic                                              mode,
  input  wire logic [bdd_pkg::SAMPLE_W-1:0]                      sample,
  output bdd_pkg::stage_ctl_t                                    ctl,
  output logic      [bdd_pkg::SAMPLE_W-1:0]                      stage_sample,
  output logic      [bdd_pkg::SAMPLE_W+$clog2(WINDOW)-1:0]       sum
);

  localparam int SUM_W  = bdd_pkg::SAMPLE_W + $clog2(WINDOW);
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW);

  logic [bdd_pkg::SAMPLE_W-1:0] tap [WINDOW];
  logic [FILL_W-1:0]            fill;
  logic [FILL_W-1:0]            fill_next;
  logic [SUM_W-1:0]             sum_next;
  logic                         shift;
  logic                         was_full;

  assign shift    = accept && (mode == bdd_pkg::MODE_AVG);
  assign was_full = (fill == FILL_FULL);

  // Chain of cells: the newest sample enters at the head, the oldest sits at the tail.
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_head
      bdd_cell u_cell (
        .clk   (clk),
        .shift (shift),
        .d     (sample),
        .q     (tap[i])
      );
    end else begin : g_link
      bdd_cell u_cell (
        .clk   (clk),
        .shift (shift),
        .d     (tap[i-1]),
        .q     (tap[i])
      );
    end
  end

  // Running sum drops the tail sample once the window is full.
  always_comb begin
    sum_next  = sum + SUM_W'(sample);
    fill_next = fill;
    if (was_full) begin
      sum_next = sum_next - SUM_W'(tap[WINDOW-1]);
    end else begin
      fill_next = fill + FILL_W'(1);
    end
  end

  // Window state and the stage register for the item in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum  <= '0;
      fill <= '0;
    end else if (shift) begin
      sum  <= sum_next;
      fill <= fill_next;
    end
    if (accept) begin
      stage_sample <= sample;
      ctl.raw      <= (mode == bdd_pkg::MODE_RAW);
      ctl.full     <= shift ? (fill_next == FILL_FULL) : was_full;
    end
  end

endmodule

`default_nettype wire

// ----- src/bdd_dwell.sv -----
// Dwell stage: window mean, band test, run counter and the result register.
`default_nettype none

module bdd_dwell #(
  parameter int WINDOW = bdd_pkg::WINDOW_DEFAULT
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  input  wire logic                                        load,
  input  wire bdd_pkg::cfg_t                               cfg,
  input  wire bdd_pkg::stage_ctl_t                         ctl,
  input  wire logic [bdd_pkg::SAMPLE_W-1:0]                stage_sample,
  input  wire logic [bdd_pkg::SAMPLE_W+$clog2(WINDOW)-1:0] sum,
  output logic                                             detected,
  output logic      [bdd_pkg::CNT_W-1:0]                   run_count,
  output logic      [bdd_pkg::SAMPLE_W-1:0]                average,
  output logic                                             window_full
);

  localparam int SUM_W  = bdd_pkg::SAMPLE_W + $clog2(WINDOW);
  localparam int SHIFT  = SUM_W + $clog2(WINDOW);
  localparam int MULT_W = SHIFT + 1;
  localparam int PROD_W = SUM_W + MULT_W;
  // Rounded-up reciprocal of the window length; exact for every possible sum.
  localparam logic [MULT_W-1:0] MULT =
    MULT_W'(((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  logic [PROD_W-1:0]            prod;
  logic [bdd_pkg::SAMPLE_W-1:0] mean;
  logic [bdd_pkg::SAMPLE_W-1:0] value;
  logic signed [bdd_pkg::SAMPLE_W+1:0] lo;
  logic signed [bdd_pkg::SAMPLE_W+1:0] hi;
  logic signed [bdd_pkg::SAMPLE_W+1:0] v;
  logic                         in_band;
  logic                         test;
  logic [bdd_pkg::CNT_W-1:0]    count;
  logic [bdd_pkg::CNT_W-1:0]    count_next;
  logic                         det_next;
  logic [bdd_pkg::SAMPLE_W-1:0] avg_next;

  // Mean of the window by multiplication with the reciprocal.
  assign prod = PROD_W'(sum) * PROD_W'(MULT);
  assign mean = prod[SHIFT +: bdd_pkg::SAMPLE_W];

  // Signed band test with inclusive bounds.
  assign value = ctl.raw ? stage_sample : mean;
  assign lo = $signed({2'b00, cfg.threshold}) - $signed({2'b00, cfg.band_width});
  assign hi = $signed({2'b00, cfg.threshold}) + $signed({2'b00, cfg.band_width});
  assign v  = $signed({2'b00, value});
  assign in_band = (v >= lo) && (v <= hi);
  assign test    = ctl.raw || ctl.full;

  // Counter update and trigger for this item.
  always_comb begin
    count_next = count;
    det_next   = 1'b0;
    avg_next   = '0;
    if (test) begin
      avg_next = value;
      if (in_band) begin
        if (count != bdd_pkg::CNT_MAX) begin
          count_next = count + bdd_pkg::CNT_W'(1);
        end
      end else begin
        count_next = cfg.count_start;
      end
      if (ctl.raw) begin
        det_next = (count_next >= cfg.duration);
      end else begin
        det_next = (count_next == cfg.duration);
      end
    end
  end

  // Run counter and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= count_next;
    end
    if (load) begin
      detected    <= det_next;
      run_count   <= count_next;
      average     <= avg_next;
      window_full <= ctl.full;
    end
  end

endmodule

`default_nettype wire

// ----- src/band_dwell_detector.sv -----
// An accepted item passes through the window stage register and then the output register.
// Throughput: one item per cycle while the output is not held by back pressure.
// The output register and the window stage register form a two-deep queue, so an item is
// accepted while a result waits. Reset clears the sum, fill level, run counter, and the
// configuration and valid flags; the sample chain is not cleared and needs no pass.
`default_nettype none

module band_dwell_detector #(
  parameter int WINDOW = bdd_pkg::WINDOW_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [bdd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bdd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [bdd_pkg::SAMPLE_W-1:0]   sample,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                detected,
  output logic      [bdd_pkg::CNT_W-1:0]      run_count,
  output logic      [bdd_pkg::SAMPLE_W-1:0]   average,
  output logic                                window_full
);

  localparam int SUM_W = bdd_pkg::SAMPLE_W + $clog2(WINDOW);

  bdd_pkg::cfg_t                cfg;
  logic                         mode;
  bdd_pkg::stage_ctl_t          ctl;
  logic [bdd_pkg::SAMPLE_W-1:0] stage_sample;
  logic [SUM_W-1:0]             sum;
  logic                         stage_valid;
  logic                         in_accept;
  logic                         out_load;

  // Handshake: the stage register moves on whenever the output register is free or draining.
  assign cfg_ready = 1'b1;
  assign out_load  = stage_valid && (!out_valid || out_ready);
  assign in_ready  = !stage_valid || out_load;
  assign in_accept = in_valid && in_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold   <= '0;
      cfg.band_width  <= '0;
      cfg.duration    <= bdd_pkg::CNT_W'(1);
      cfg.count_start <= '0;
      mode            <= bdd_pkg::MODE_AVG;
    end else if (cfg_valid) begin
      unique case (bdd_pkg::cfg_reg_t'(cfg_index))
        bdd_pkg::REG_THRESHOLD:   cfg.threshold   <= cfg_data[bdd_pkg::SAMPLE_W-1:0];
        bdd_pkg::REG_BAND_WIDTH:  cfg.band_width  <= cfg_data[bdd_pkg::SAMPLE_W-1:0];
        bdd_pkg::REG_DURATION:    cfg.duration    <= cfg_data[bdd_pkg::CNT_W-1:0];
        bdd_pkg::REG_MODE:        mode            <= cfg_data[0];
        bdd_pkg::REG_COUNT_START: cfg.count_start <= cfg_data[bdd_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Valid flags of the two stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (in_accept) begin
        stage_valid <= 1'b1;
      end else if (out_load) begin
        stage_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  bdd_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk          (clk),
    .rst          (rst),
    .accept       (in_accept),
    .mode         (mode),
    .sample       (sample),
    .ctl          (ctl),
    .stage_sample (stage_sample),
    .sum          (sum)
  );

  bdd_dwell #(
    .WINDOW (WINDOW)
  ) u_dwell (
    .clk          (clk),
    .rst          (rst),
    .load         (out_load),
    .cfg          (cfg),
    .ctl          (ctl),
    .stage_sample (stage_sample),
    .sum          (sum),
    .detected     (detected),
    .run_count    (run_count),
    .average      (average),
    .window_full  (window_full)
  );

  // A result only appears when an item was waiting in the window stage.
  a_out_from_stage: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(stage_valid))
    else $error("result appeared with no item in the window stage");

  // Input is held off only by back pressure from a full output register.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && !in_ready) |-> (out_valid && !out_ready))
    else $error("input stalled without output back pressure");

  // A taken result with nothing behind it leaves the output empty.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !stage_valid) |=> !out_valid)
    else $error("output stayed valid after draining");

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the band dwell detector, with directed and random sample streams.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN               = bdd_pkg::WINDOW_DEFAULT;
  localparam int SAMPLE_MAX        = (1 << bdd_pkg::SAMPLE_W) - 1;
  localparam int QUIET_LIMIT       = 4000;
  localparam int SETTLE_CYCLES     = 4;
  localparam int ITEMS_PER_SETTING = 50;

  // One result item as the block presents it.
  typedef struct packed {
    logic                         detected;
    logic [bdd_pkg::CNT_W-1:0]    run_count;
    logic [bdd_pkg::SAMPLE_W-1:0] average;
    logic                         window_full;
  } dwell_result_t;

  logic                           clk         = 1'b0;
  logic                           rst         = 1'b1;
  logic                           cfg_valid   = 1'b0;
  logic                           cfg_ready;
  logic [bdd_pkg::CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [bdd_pkg::CFG_DATA_W-1:0] cfg_data    = '0;
  logic                           in_valid    = 1'b0;
  logic                           in_ready;
  logic [bdd_pkg::SAMPLE_W-1:0]   sample      = '0;
  logic                           out_valid;
  logic                           out_ready   = 1'b0;
  logic                           detected;
  logic [bdd_pkg::CNT_W-1:0]      run_count;
  logic [bdd_pkg::SAMPLE_W-1:0]   average;
  logic                           window_full;

  // Shadow copy of the register set.
  logic [bdd_pkg::SAMPLE_W-1:0]   shadow_threshold   = '0;
  logic [bdd_pkg::SAMPLE_W-1:0]   shadow_band        = '0;
  logic [bdd_pkg::CNT_W-1:0]      shadow_duration    = 1;
  logic                           shadow_mode        = bdd_pkg::MODE_AVG;
  logic [bdd_pkg::CNT_W-1:0]      shadow_count_start = '0;

  // Shadow copy of the window and the dwell counter.
  logic [bdd_pkg::SAMPLE_W-1:0]   ring_copy [WIN];
  int                             sum_copy   = 0;
  int                             fill_copy  = 0;
  int                             ptr_copy   = 0;
  logic [bdd_pkg::CNT_W-1:0]      dwell_copy = '0;

  dwell_result_t                  expected_results [$];
  int                             mismatches     = 0;
  int                             quiet_cycles   = 0;
  int                             send_idle_pct  = 0;
  int                             recv_stall_pct = 0;

  band_dwell_detector DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample      (sample),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .detected    (detected),
    .run_count   (run_count),
    .average     (average),
    .window_full (window_full)
  );

  always #2 clk = ~clk;

  // Works out the result of one sample and advances the shadow state.
  function automatic dwell_result_t predict_dwell(input logic [bdd_pkg::SAMPLE_W-1:0] value);
    dwell_result_t res;
    int            probe;
    int            lo_edge;
    int            hi_edge;
    bit            tested;
    res    = '0;
    probe  = 0;
    tested = 1'b0;
    if (shadow_mode == bdd_pkg::MODE_AVG) begin
      // The ring fills first; once full, the oldest sample leaves the sum.
      if (fill_copy < WIN) begin
        fill_copy++;
      end else begin
        sum_copy -= int'(ring_copy[ptr_copy]);
      end
      ring_copy[ptr_copy] = value;
      sum_copy += int'(value);
      ptr_copy = (ptr_copy + 1) % WIN;
      if (fill_copy == WIN) begin
        probe  = sum_copy / WIN;
        tested = 1'b1;
      end
    end else begin
      probe  = int'(value);
      tested = 1'b1;
    end
    if (tested) begin
      // The band test is signed, so a lower edge below zero fails no value on that side.
      lo_edge = int'(shadow_threshold) - int'(shadow_band);
      hi_edge = int'(shadow_threshold) + int'(shadow_band);
      if (probe >= lo_edge && probe <= hi_edge) begin
        if (dwell_copy != bdd_pkg::CNT_MAX) dwell_copy++;
      end else begin
        dwell_copy = shadow_count_start;
      end
      res.average  = probe[bdd_pkg::SAMPLE_W-1:0];
      res.detected = (shadow_mode == bdd_pkg::MODE_AVG) ? (dwell_copy == shadow_duration)
                                                        : (dwell_copy >= shadow_duration);
    end
    res.run_count   = dwell_copy;
    res.window_full = (fill_copy == WIN);
    return res;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Offers one sample, idling first at random, and records its expected result.
  task automatic send_sample(input logic [bdd_pkg::SAMPLE_W-1:0] value);
    dwell_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    res = predict_dwell(value);
    expected_results.insert(expected_results.size(), res);
  endtask

  // Stops sending and waits until every outstanding result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes one register; hold keeps valid up for a following write.
  task automatic write_reg(input logic [bdd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bdd_pkg::CFG_DATA_W-1:0] data, input bit hold);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      bdd_pkg::REG_THRESHOLD:   shadow_threshold   = data[bdd_pkg::SAMPLE_W-1:0];
      bdd_pkg::REG_BAND_WIDTH:  shadow_band        = data[bdd_pkg::SAMPLE_W-1:0];
      bdd_pkg::REG_DURATION:    shadow_duration    = data[bdd_pkg::CNT_W-1:0];
      bdd_pkg::REG_MODE:        shadow_mode        = data[0];
      bdd_pkg::REG_COUNT_START: shadow_count_start = data[bdd_pkg::CNT_W-1:0];
      default: ;
    endcase
    if (!hold) cfg_valid <= 1'b0;
  endtask

  // Drains the block, then writes the whole register set with random unused upper bits.
  task automatic configure(input int thr, input int bw, input int dur, input logic md,
                           input int cs);
    logic [bdd_pkg::CFG_DATA_W-1:0] noise;
    drain();
    noise = $urandom;
    write_reg(bdd_pkg::REG_THRESHOLD,
              {noise[bdd_pkg::CFG_DATA_W-1:bdd_pkg::SAMPLE_W], thr[bdd_pkg::SAMPLE_W-1:0]},
              1'b1);
    noise = $urandom;
    write_reg(bdd_pkg::REG_BAND_WIDTH,
              {noise[bdd_pkg::CFG_DATA_W-1:bdd_pkg::SAMPLE_W], bw[bdd_pkg::SAMPLE_W-1:0]},
              1'b1);
    write_reg(bdd_pkg::REG_DURATION, dur[bdd_pkg::CFG_DATA_W-1:0], 1'b1);
    noise = $urandom;
    write_reg(bdd_pkg::REG_MODE, {noise[bdd_pkg::CFG_DATA_W-1:1], md}, 1'b1);
    write_reg(bdd_pkg::REG_COUNT_START, cs[bdd_pkg::CFG_DATA_W-1:0], 1'b0);
  endtask

  // Random stream in bursts near the band with some noise, under changing settings.
  task automatic random_session(input bit pick_mode, input logic fixed_mode, input int items);
    int   thr;
    int   bw;
    int   dur;
    int   cs;
    int   v;
    int   run_left;
    logic md;
    run_left = 0;
    for (int n = 0; n < items; n++) begin
      if (n % ITEMS_PER_SETTING == 0) begin
        case ((3 * n) / items)
          0: begin
            send_idle_pct  = 25;
            recv_stall_pct = 87;
          end
          1: begin
            send_idle_pct  = 87;
            recv_stall_pct = 25;
          end
          default: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
          end
        endcase
        md  = pick_mode ? logic'($urandom_range(1)) : fixed_mode;
        thr = $urandom_range(SAMPLE_MAX);
        case ($urandom_range(4))
          0:       bw = 0;
          1:       bw = SAMPLE_MAX;
          2:       bw = $urandom_range(SAMPLE_MAX);
          default: bw = $urandom_range(24);
        endcase
        case ($urandom_range(5))
          0:       dur = 0;
          1:       dur = int'(bdd_pkg::CNT_MAX);
          2:       dur = $urandom_range(int'(bdd_pkg::CNT_MAX));
          default: dur = $urandom_range(12);
        endcase
        case ($urandom_range(5))
          0:       cs = int'(bdd_pkg::CNT_MAX);
          1:       cs = int'(bdd_pkg::CNT_MAX) - int'($urandom_range(8));
          2:       cs = $urandom_range(int'(bdd_pkg::CNT_MAX));
          default: cs = $urandom_range(3);
        endcase
        configure(thr, bw, dur, md, cs);
        run_left = 0;
      end
      if (run_left == 0 && $urandom_range(3) == 0) begin
        v = $urandom_range(SAMPLE_MAX);
      end else begin
        if (run_left == 0) run_left = $urandom_range(20, 1);
        run_left--;
        v = int'(shadow_threshold) - int'(shadow_band) - 2
            + int'($urandom_range(2 * int'(shadow_band) + 4));
        if (v < 0) v = 0;
        if (v > SAMPLE_MAX) v = SAMPLE_MAX;
      end
      send_sample(v[bdd_pkg::SAMPLE_W-1:0]);
    end
  endtask

  // Reset values: the window fills, then the all-zero mean sits on a zero-wide band.
  task automatic test_reset_values();
    repeat (WIN) send_sample('0);
    send_sample('1);
    send_sample('0);
  endtask

  // Raw mode: both inclusive band edges, one step outside each, at-least trigger.
  task automatic test_raw_band_edges();
    configure(512, 10, 2, bdd_pkg::MODE_RAW, 0);
    send_sample(10'd502);
    send_sample(10'd522);
    send_sample(10'd523);
    send_sample(10'd501);
    send_sample(10'd512);
  endtask

  // A band wider than its centre puts the lower edge below zero.
  task automatic test_lower_edge_negative();
    configure(3, SAMPLE_MAX, 3, bdd_pkg::MODE_AVG, 0);
    send_sample('0);
    send_sample('1);
    send_sample('0);
  endtask

  // The counter loaded near its top must stick at full scale.
  task automatic test_counter_saturation();
    configure(0, 0, int'(bdd_pkg::CNT_MAX), bdd_pkg::MODE_RAW, int'(bdd_pkg::CNT_MAX) - 1);
    send_sample(10'd1);
    send_sample('0);
    send_sample('0);
  endtask

  // A new count_start value waits for the next out-of-band test.
  task automatic test_count_start_no_reload();
    configure(100, 0, 0, bdd_pkg::MODE_RAW, 7);
    send_sample(10'd5);
    send_sample(10'd100);
    drain();
    write_reg(bdd_pkg::REG_COUNT_START, 16'd20, 1'b0);
    send_sample(10'd100);
    send_sample(10'd5);
  endtask

  // Writes above the last register must change nothing.
  task automatic test_spare_indexes();
    drain();
    for (int k = int'(bdd_pkg::REG_COUNT_START) + 1; k < (1 << bdd_pkg::CFG_IDX_W); k++)
      write_reg(k[bdd_pkg::CFG_IDX_W-1:0], '1, k != (1 << bdd_pkg::CFG_IDX_W) - 1);
    send_sample(10'd100);
    send_sample(10'd5);
  endtask

  // Switching mode mid-stream keeps the ring and the counter.
  task automatic test_mode_switch();
    configure(0, SAMPLE_MAX, 0, bdd_pkg::MODE_AVG, 0);
    send_sample(10'd300);
    configure(0, SAMPLE_MAX, 0, bdd_pkg::MODE_RAW, 0);
    send_sample('1);
    configure(0, SAMPLE_MAX, 0, bdd_pkg::MODE_AVG, 0);
    send_sample('0);
  endtask

  task automatic test_random_averaged();
    random_session(1'b0, bdd_pkg::MODE_AVG, 300);
  endtask

  task automatic test_random_raw();
    random_session(1'b0, bdd_pkg::MODE_RAW, 300);
  endtask

  task automatic test_random_mixed();
    random_session(1'b1, bdd_pkg::MODE_AVG, 300);
  endtask

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each accepted result with the oldest expected one.
  always @(posedge clk) begin
    dwell_result_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (expected_results.size() == 0) begin
        flag_mismatch("result item with no sample outstanding");
      end else begin
        want = expected_results.pop_front();
        if (detected !== want.detected)
          flag_mismatch($sformatf("detected got %0b want %0b", detected, want.detected));
        if (run_count !== want.run_count)
          flag_mismatch($sformatf("run_count got %0d want %0d", run_count, want.run_count));
        if (average !== want.average)
          flag_mismatch($sformatf("average got %0d want %0d", average, want.average));
        if (window_full !== want.window_full)
          flag_mismatch($sformatf("window_full got %0b want %0b", window_full,
                                  want.window_full));
      end
    end
  end

  // Ends the run if no channel moves an item for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_raw_band_edges();
    test_lower_edge_negative();
    test_counter_saturation();
    test_count_start_no_reload();
    test_spare_indexes();
    test_mode_switch();
    test_random_averaged();
    test_random_raw();
    test_random_mixed();
    drain();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- band_dwell_detector.f -----
src/bdd_pkg.sv
src/bdd_cell.sv
src/bdd_window.sv
src/bdd_dwell.sv
src/band_dwell_detector.sv
tb/sv/tb.sv
